// ===== sv/swm_pkg.sv =====
package swm_pkg;

   // Per-cell steering for one update of the sorted row. The removed slot is
   // the oldest sample when the window is full, otherwise the first empty slot.
   typedef struct packed {
      logic rm_in_prefix;   // removed slot holds a value not above the new sample
      logic rm_after;       // removed slot index is above this cell
      logic rm_at_or_after; // removed slot index is this cell or above
      logic le_below;       // lower neighbor is valid and not above the sample
      logic le_self;        // this cell is valid and not above the sample
      logic le_above;       // upper neighbor is valid and not above the sample
   } swm_cell_ctl_type;

   // Result register control.
   typedef struct packed {
      logic advance; // a pending median moves into the result register
      logic drain;   // the result item is taken downstream
   } swm_out_ctl_type;

endpackage

// ===== sv/swm_req_if.sv =====
interface swm_req_if #(
   parameter int SAMPLE_BITS = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          start_req;

   modport source (output valid, output sample, output start_req, input ready);
   modport sink   (input valid, input sample, input start_req, output ready);
endinterface

// ===== sv/swm_rsp_if.sv =====
interface swm_rsp_if #(
   parameter int SAMPLE_BITS = 32
) ();
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_BITS:0] median_x2;

   modport source (output valid, output median_x2, input ready);
   modport sink   (input valid, input median_x2, output ready);
endinterface

// ===== sv/swm_cell.sv =====
module swm_cell import swm_pkg::*; #(
   parameter int SAMPLE_BITS = 32,
   parameter int AGE_W       = 6
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  swm_cell_ctl_type              ctl,
   input  logic signed [SAMPLE_BITS-1:0] below_value,
   input  logic        [AGE_W-1:0]       below_age,
   input  logic signed [SAMPLE_BITS-1:0] above_value,
   input  logic        [AGE_W-1:0]       above_age,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic        [AGE_W-1:0]       age,
   output logic                          not_above
);

   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic        [AGE_W-1:0]       age_ff, age_in;

   assign not_above = !(sample < value_ff);

   // Each cell keeps its value, takes a neighbor's, or takes the new sample.
   always_comb begin
      value_in = value_ff;
      age_in   = age_ff + AGE_W'(1);
      if (ctl.rm_in_prefix) begin
         if (ctl.rm_after) begin
            value_in = value_ff;
         end else if (ctl.le_above) begin
            value_in = above_value;
            age_in   = above_age + AGE_W'(1);
         end else if (ctl.le_self) begin
            value_in = sample;
            age_in   = '0;
         end
      end else begin
         if (ctl.le_self) begin
            value_in = value_ff;
         end else if (ctl.le_below) begin
            value_in = sample;
            age_in   = '0;
         end else if (ctl.rm_at_or_after) begin
            value_in = below_value;
            age_in   = below_age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;

endmodule

// ===== sv/swm_row.sv =====
module swm_row import swm_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32,
   parameter int KW          = 7,
   parameter int AW          = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          load,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic        [KW-1:0]          window_k,
   output logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW],
   output logic                          produce
);

   logic [KW-1:0]    fill_ff, fill_in;
   logic [KW-1:0]    fill_eff;
   logic             full;
   logic [AW-1:0]    k_minus_one;
   logic [AW-1:0]    rm_idx;
   logic             rm_in_prefix;
   logic [MAX_WINDOW-1:0] le;
   logic [MAX_WINDOW-1:0] hit;
   logic [MAX_WINDOW-1:0] not_above;
   logic [AW-1:0]    cell_age [MAX_WINDOW];
   swm_cell_ctl_type ctl [MAX_WINDOW];

   assign fill_eff    = start ? '0 : fill_ff;
   assign full        = (fill_eff == window_k);
   assign k_minus_one = AW'(window_k - KW'(1));
   assign produce     = full || ((fill_eff + KW'(1)) == window_k);

   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         le[i]  = (KW'(i) < fill_eff) && not_above[i];
         hit[i] = full && (KW'(i) < fill_eff) && (cell_age[i] == k_minus_one);
      end
   end

   // Index of the slot that frees up: the oldest sample, or the first empty one.
   always_comb begin
      rm_idx       = '0;
      rm_in_prefix = 1'b0;
      if (full) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            if (hit[i]) begin
               rm_idx = rm_idx | AW'(i);
            end
         end
         rm_in_prefix = |(hit & le);
      end else begin
         rm_idx = AW'(fill_eff);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (clear) begin
         fill_in = '0;
      end else if (load) begin
         fill_in = full ? fill_eff : fill_eff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] below_value, above_value;
      logic        [AW-1:0]          below_age, above_age;
      logic                          le_below, le_above;

      if (i == 0) begin : g_first
         assign below_value = cell_value[i];
         assign below_age   = cell_age[i];
         assign le_below    = 1'b1;
      end else begin : g_inner_low
         assign below_value = cell_value[i-1];
         assign below_age   = cell_age[i-1];
         assign le_below    = le[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign above_value = cell_value[i];
         assign above_age   = cell_age[i];
         assign le_above    = 1'b0;
      end else begin : g_inner_high
         assign above_value = cell_value[i+1];
         assign above_age   = cell_age[i+1];
         assign le_above    = le[i+1];
      end

      always_comb begin
         ctl[i].rm_in_prefix   = rm_in_prefix;
         ctl[i].rm_after       = (rm_idx > AW'(i));
         ctl[i].rm_at_or_after = (rm_idx >= AW'(i));
         ctl[i].le_below       = le_below;
         ctl[i].le_self        = le[i];
         ctl[i].le_above       = le_above;
      end

      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_W       (AW)
      ) u_cell (
         .clock       (clock),
         .load        (load),
         .sample      (sample),
         .ctl         (ctl[i]),
         .below_value (below_value),
         .below_age   (below_age),
         .above_value (above_value),
         .above_age   (above_age),
         .value       (cell_value[i]),
         .age         (cell_age[i]),
         .not_above   (not_above[i])
      );
   end

endmodule

// ===== sv/swm_out.sv =====
module swm_out import swm_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32,
   parameter int KW          = 7,
   parameter int AW          = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          set_k,
   input  logic        [KW-1:0]          k_new,
   input  swm_out_ctl_type               ctl,
   input  logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW],
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS:0]   median_x2
);

   logic [MAX_WINDOW-1:0]         sel_lo_ff, sel_lo_in;
   logic [MAX_WINDOW-1:0]         sel_hi_ff, sel_hi_in;
   logic [AW-1:0]                 lo_idx, hi_idx;
   logic signed [SAMPLE_BITS-1:0] lo_value, hi_value;
   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS:0]   median_ff, median_in;

   // The two middle positions only change with the window length.
   assign lo_idx = AW'((k_new - KW'(1)) >> 1);
   assign hi_idx = AW'(k_new >> 1);

   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         sel_lo_in[i] = (lo_idx == AW'(i));
         sel_hi_in[i] = (hi_idx == AW'(i));
      end
   end

   always_comb begin
      lo_value = '0;
      hi_value = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         lo_value = lo_value | (sel_lo_ff[i] ? cell_value[i] : '0);
         hi_value = hi_value | (sel_hi_ff[i] ? cell_value[i] : '0);
      end
   end

   assign median_in = (SAMPLE_BITS+1)'(lo_value) + (SAMPLE_BITS+1)'(hi_value);
   assign valid_in  = ctl.advance ? 1'b1 : (ctl.drain ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_lo_ff <= MAX_WINDOW'(1);
         sel_hi_ff <= MAX_WINDOW'(1);
         valid_ff  <= 1'b0;
      end else begin
         if (set_k) begin
            sel_lo_ff <= sel_lo_in;
            sel_hi_ff <= sel_hi_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         median_ff <= median_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign median_x2 = median_ff;

endmodule

// ===== sv/sliding_window_median.sv =====
// Sliding-window median filter. Each req item carries a signed sample and a
// start_req flag that empties the window before the sample goes in. The block
// keeps the last k samples as a row of sorted cells, each tagged with its age,
// so the oldest sample is found and dropped in the same update that inserts
// the new one. Once k samples have arrived since the last start, a csr write or
// reset, every item yields one rsp item holding twice the median: double the
// middle value for odd k, or the sum of the two middle values for even k, so
// the result is exact. Throughput is one item per clock cycle while req_ready
// stays high: the whole remove-and-insert step is a single parallel update of
// the cell row, and the median is then read from the row and added into the
// result register once that register is free. req_ready
// drops only while a finished result waits in the result register and another
// one is already pending behind it. The window length k is written through
// csr_wdata with csr_we; zero acts as one, values above MAX_WINDOW act as
// MAX_WINDOW, and every write empties the window. Write it only while idle.
module sliding_window_median import swm_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   swm_req_if.sink    req_bus,
   swm_rsp_if.source  rsp_bus,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);

   localparam int KW = $clog2(MAX_WINDOW + 1);
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [KW-1:0]                 k_ff, k_in;
   logic                          pend_ff, pend_in;
   logic                          accept;
   logic                          produce;
   logic                          rsp_valid;
   swm_out_ctl_type               out_ctl;
   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];

   // Clamp the written window length into the range the row supports.
   always_comb begin
      if (csr_wdata == 7'd0) begin
         k_in = KW'(1);
      end else if (32'(csr_wdata) > 32'(MAX_WINDOW)) begin
         k_in = KW'(MAX_WINDOW);
      end else begin
         k_in = KW'(csr_wdata);
      end
   end

   // A pending median sits in the cell row until the result register frees up.
   // While it waits, the row must not change, so req_ready follows it.
   assign out_ctl.drain   = rsp_bus.ready;
   assign out_ctl.advance = pend_ff && (!rsp_valid || rsp_bus.ready);
   assign req_bus.ready   = !pend_ff || out_ctl.advance;
   assign accept          = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept) begin
         pend_in = produce;
      end else if (out_ctl.advance) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= KW'(1);
         pend_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            k_ff <= k_in;
         end
         pend_ff <= pend_in;
      end
   end

   swm_row #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .KW          (KW),
      .AW          (AW)
   ) u_row (
      .clock      (clock),
      .reset      (reset),
      .clear      (csr_we),
      .load       (accept),
      .start      (req_bus.start_req),
      .sample     (req_bus.sample),
      .window_k   (k_ff),
      .cell_value (cell_value),
      .produce    (produce)
   );

   swm_out #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .KW          (KW),
      .AW          (AW)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .set_k      (csr_we),
      .k_new      (k_in),
      .ctl        (out_ctl),
      .cell_value (cell_value),
      .rsp_valid  (rsp_valid),
      .median_x2  (rsp_bus.median_x2)
   );

   assign rsp_bus.valid = rsp_valid;

endmodule

// ===== sv/swm_checker.sv =====
module swm_checker #(
   parameter int SAMPLE_BITS = 32
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [SAMPLE_BITS:0] median_x2
);

   // A result item that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item withdrawn before it was taken");

   // A stalled result item keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(median_x2))
      else $error("stalled result item changed");

   // Reset empties the result register.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item offered right after reset");

   // The input side only stalls behind a result that is held up downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result item");

endmodule

bind sliding_window_median swm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .median_x2 (rsp_bus.median_x2)
);

// ===== sim/median_checker.sv =====
module median_checker #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   swm_req_if         req_bus,
   swm_rsp_if         rsp_bus,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata,
   output int         error_total,
   output int         open_items
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [6:0]                    window_reg;
   logic signed [SAMPLE_BITS-1:0] arrival_samples [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] ranked_samples [MAX_WINDOW];
   int                            held_count;
   int                            oldest_slot;
   int                            result_count;
   logic signed [SAMPLE_BITS:0]   expected_medians [$];

   task automatic report_mismatch(input string msg);
      $display("%0t: median check failed: %s", $time, msg);
      error_total++;
   endtask

   // Takes one accepted sample into the window copy and queues twice the
   // median once the window is full.
   task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                input logic restart);
      int                          depth;
      int                          pos;
      int                          idx;
      logic signed [SAMPLE_BITS:0] twice;
      depth = (window_reg == 0) ? 1 : ((window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg);
      if (restart) begin
         held_count  = 0;
         oldest_slot = 0;
      end
      if (held_count >= depth) begin
         held_count = depth;
         if (oldest_slot >= depth) begin
            oldest_slot = 0;
         end
         // Drop one copy of the oldest value from the sorted row.
         pos = 0;
         while (pos < held_count && ranked_samples[pos] != arrival_samples[oldest_slot]) begin
            pos++;
         end
         if (pos < held_count) begin
            for (idx = pos; idx < held_count - 1; idx++) begin
               ranked_samples[idx] = ranked_samples[idx + 1];
            end
            held_count--;
         end
         arrival_samples[oldest_slot] = value;
         oldest_slot = (oldest_slot + 1 == depth) ? 0 : oldest_slot + 1;
      end else begin
         arrival_samples[held_count] = value;
      end
      pos = held_count;
      while (pos > 0 && value < ranked_samples[pos - 1]) begin
         ranked_samples[pos] = ranked_samples[pos - 1];
         pos--;
      end
      ranked_samples[pos] = value;
      held_count++;
      if (held_count >= depth) begin
         if (depth % 2 == 1) begin
            twice = ranked_samples[(depth - 1) / 2] + ranked_samples[(depth - 1) / 2];
         end else begin
            twice = ranked_samples[depth / 2 - 1] + ranked_samples[depth / 2];
         end
         expected_medians = {expected_medians, twice};
      end
   endtask

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS:0] wanted;
      if (reset) begin
         window_reg  = 7'd1;
         held_count  = 0;
         oldest_slot = 0;
         expected_medians.delete();
      end else begin
         if (csr_we) begin
            window_reg  = csr_wdata;
            held_count  = 0;
            oldest_slot = 0;
         end
         if (req_bus.valid && req_bus.ready) begin
            absorb_sample(req_bus.sample, req_bus.start_req);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_medians.size() == 0) begin
               report_mismatch($sformatf("result %0d = %0d arrived with none expected",
                                         result_count, rsp_bus.median_x2));
            end else begin
               wanted = expected_medians.pop_front();
               if (rsp_bus.median_x2 !== wanted) begin
                  report_mismatch($sformatf("result %0d median_x2 = %0d, expected %0d",
                                            result_count, rsp_bus.median_x2, wanted));
               end
            end
         end
      end
      open_items <= expected_medians.size();
   end

endmodule

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WINDOW    = 64;
   localparam int SAMPLE_BITS   = 32;
   // Cycles the receiver holds off in the pressure test; far more than the
   // few items the block can buffer.
   localparam int HOLD_CYCLES   = 60;
   // Extra cycles allowed after the last expected result, as a margin for the
   // block to settle.
   localparam int SETTLE_CYCLES = 4;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // How the values of one random sequence are drawn.
   typedef enum int {
      FULL_RANGE,
      NARROW,
      EXTREMES
   } sample_style_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       csr_we    = 1'b0;
   logic [6:0] csr_wdata = 7'd0;
   int         fail_total;
   int         open_items;

   // Idling controls shared between the stimulus and the receiver.
   bit         sender_idles   = 1'b1;
   bit         receiver_idles = 1'b1;
   bit         hold_wanted    = 1'b0;

   swm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   swm_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   sliding_window_median #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   median_checker #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_total (fail_total),
      .open_items  (open_items)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs or loses results. This is several
   // times longer than the slowest correct run needs.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input sample_style_type style);
      case (style)
         NARROW: begin
            // A tight range makes equal samples common, which exercises
            // removal of one copy among several.
            return int'($urandom_range(0, 6)) - 3;
         end
         EXTREMES: begin
            case ($urandom_range(0, 4))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   // Offers one item and returns at the clock edge where it is accepted.
   // The valid line stays high on return, so back-to-back items need no
   // extra assignment in the same time step.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic restart);
      int gap;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample    <= value;
      req_bus.start_req <= restart;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stops offering items and waits until every expected result has come
   // back, then lets the block settle.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (open_items != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The window length may only change while the block is idle; every write
   // also empties the window.
   task automatic write_window(input logic [6:0] value);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Receiver: draws a fresh wait before every result item and, when asked,
   // holds off for a long stretch so that the block backs up into its input.
   initial begin
      int pause;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         pause = receiver_idles ? $urandom_range(0, 5) : 0;
         if (pause > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      logic [6:0]       sizes [$];
      sample_style_type style;
      int               depth;
      int               sent;
      int               length;
      int               idx;
      bit               lead_start;

      req_bus.valid     <= 1'b0;
      req_bus.sample    <= '0;
      req_bus.start_req <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The window length is 1 out of reset, so each item
      // returns twice its own value; the field extremes go through first.
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(0, 1'b0);
      send_sample(-1, 1'b0);

      // A length of zero must act as one.
      write_window(7'd0);
      send_sample(7, 1'b1);
      send_sample(-7, 1'b0);

      // Odd window with repeated values: when a 5 leaves, only one of the
      // equal entries may go. The extremes then enter a full window.
      write_window(7'd3);
      send_sample(5, 1'b1);
      send_sample(5, 1'b0);
      send_sample(-7, 1'b0);
      send_sample(5, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);

      // Even window: the result is the sum of the two middle values. A start item
      // in the middle of a full window must empty it before the sample enters.
      write_window(7'd4);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(3, 1'b1);
      send_sample(3, 1'b0);
      send_sample(-2, 1'b0);
      send_sample(9, 1'b0);

      // Random part: one phase per window length, including both ends of
      // the register and lengths above the largest window.
      sizes = '{7'd2, 7'd64, 7'd5, 7'd127, 7'd0, 7'd1, 7'd4, 7'd65, 7'd9, 7'd33};
      sizes = {sizes, 7'($urandom_range(0, 127))};
      sizes = {sizes, 7'($urandom_range(1, 16))};

      foreach (sizes[p]) begin
         write_window(sizes[p]);
         depth = (sizes[p] == 0) ? 1 : ((sizes[p] > MAX_WINDOW) ? MAX_WINDOW : sizes[p]);

         if (p == 0) begin
            // Pressure: the receiver stalls for a long stretch while items
            // keep coming without gaps, so the block has to refuse input.
            // Afterwards the sender waits for every outstanding result.
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
            hold_wanted    = 1'b1;
            for (idx = 0; idx < 40; idx++) begin
               send_sample(draw_sample(FULL_RANGE), idx == 0);
            end
            wait_for_drain();
         end

         sent = 0;
         while (sent < 65) begin
            // Most sequences begin with a start item and run past the fill
            // point; a few are cut short or carry on from the previous one.
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
            style          = sample_style_type'($urandom_range(0, 2));
            lead_start     = $urandom_range(0, 9) != 0;
            if ($urandom_range(0, 6) == 0) begin
               length = $urandom_range(1, depth);
            end else begin
               length = depth + $urandom_range(0, depth + 20);
            end
            for (idx = 0; idx < length; idx++) begin
               send_sample(draw_sample(style),
                           (idx == 0 && lead_start) || $urandom_range(0, 99) == 0);
            end
            sent += length;
         end
      end

      wait_for_drain();
      if (fail_total == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
